// File: hdl/npcg_pkg.sv
// Shared constants and helpers for the narrowphase contact generator.
package npcg_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    // A box has this many corners.
    localparam int NUM_CORNERS = 8;

    // Pair kinds carried in the mode field.
    localparam logic [1:0] MODE_SPH_SPH = 2'd0;
    localparam logic [1:0] MODE_SPH_PLN = 2'd1;
    localparam logic [1:0] MODE_BOX_PLN = 2'd2;

    // Negative half-size sign per axis, one bit per corner number (bit k is corner k).
    localparam logic [2:0][7:0] CORNER_NEG = {8'b0110_0110, 8'b0000_1111, 8'b1100_1100};

    // Width of the wide signed values handed to the saturation helper.
    localparam int SATW = 72;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic [31:0] sat32(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] hi_lim;
        logic signed [SATW-1:0] lo_lim;
        hi_lim = SATW'(64'sd2147483647);
        lo_lim = SATW'(-64'sd2147483648);
        if (v > hi_lim) begin
            return 32'h7FFF_FFFF;
        end else if (v < lo_lim) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// File: hdl/narrowphase_contact_generator.sv
// Narrowphase contact generator: pipelined sphere and box contact tests against spheres/planes.
//
//  Channel  Direction  Handshake            Beat contents
//  input    in         i_valid / o_ready    one primitive pair (mode, tag, centers, extents)
//  result   out        o_valid / i_ready    one contact (tag, point, normal, depth, corner, last)
//
// A sphere pair issues a single beat; a box-plane pair issues eight, one per corner,
// since the corner sequencer issues one corner beat per cycle while not stalled.
// Square root at one bit per stage, then FRAC_BITS + 1 stages of restoring
// division, dominate the depth of the pipeline.
// Reset is synchronous and active low; it clears only valid and sequencing state.
// A stall at the result side freezes the whole pipeline; no beat is lost or repeated.
module narrowphase_contact_generator #(
    parameter int FRAC_BITS = npcg_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic [15:0]        i_pair_tag,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic [30:0]        i_a_ext_x,
    input  logic [30:0]        i_a_ext_y,
    input  logic [30:0]        i_a_ext_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_b_scalar,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_tag_out,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    output logic signed [31:0] o_normal_x,
    output logic signed [31:0] o_normal_y,
    output logic signed [31:0] o_normal_z,
    output logic signed [31:0] o_depth,
    output logic [2:0]         o_corner,
    output logic               o_last
);

    // Datapath widths.
    localparam int UW    = 33;             // offset or corner coordinate
    localparam int PW    = 66;             // first product
    localparam int ACCW  = 68;             // dot product or squared distance sum
    localparam int SW    = 66;             // square root radicand
    localparam int RW    = 33;             // square root result bits
    localparam int DVW   = 33 + FRAC_BITS; // division remainder
    localparam int QW    = FRAC_BITS + 1;  // normal magnitude bits
    localparam int MAGW  = 50;             // clamped plane distance magnitude
    localparam int SPLIT = 25;             // partial product split of the plane magnitude
    localparam int PPW   = 32 + SPLIT;     // one partial product
    localparam int FW    = 32 + MAGW;      // recombined product
    localparam int QMW   = 35;             // clamped correction magnitude

    // Stage numbering.
    localparam int S_MUL1 = 1;
    localparam int S_TRN  = 2;
    localparam int S_ACC  = 3;
    localparam int S_CLS  = 4;
    localparam int S_SQ0  = 5;
    localparam int S_DST  = S_SQ0 + RW;
    localparam int S_DV0  = S_DST + 1;
    localparam int S_NRM  = S_DV0 + QW;
    localparam int S_MUL2 = S_NRM + 1;
    localparam int S_QS   = S_MUL2 + 1;
    localparam int S_PNT  = S_QS + 1;
    localparam int NST    = S_PNT + 1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [15:0]       tag;
        logic [2:0][31:0]  a;
        logic [2:0][30:0]  h;
        logic [2:0][31:0]  b;
        logic [31:0]       bs;
    } t_item;

    typedef struct packed {
        logic [1:0]             mode;
        logic [15:0]            tag;
        logic [2:0][31:0]       a;
        logic [30:0]            h0;
        logic [2:0][31:0]       b;
        logic [31:0]            bs;
        logic [2:0]             corner;
        logic                   eoi;
        logic [2:0][UW-1:0]     u;
        logic [2:0][PW-1:0]     prod;
        logic [ACCW-1:0]        acc;
        logic [SW-1:0]          srem;
        logic [RW-1:0]          root;
        logic                   hit;
        logic [31:0]            depth;
        logic [2:0][31:0]       normal;
        logic [2:0][31:0]       point;
        logic [MAGW-1:0]        pmag;
        logic                   pneg;
        logic [2:0][DVW-1:0]    drem;
        logic [2:0][QW-1:0]     quo;
        logic [2:0][31:0]       mx;
        logic [2:0][SPLIT-1:0]  ylo;
        logic [2:0][SPLIT-1:0]  yhi;
        logic [2:0]             qneg;
        logic [2:0][PPW-1:0]    pplo;
        logic [2:0][PPW-1:0]    pphi;
        logic [2:0][QMW-1:0]    qm;
    } t_beat;

    typedef struct packed {
        logic [15:0]      tag;
        logic [2:0][31:0] point;
        logic [2:0][31:0] normal;
        logic [31:0]      depth;
        logic [2:0]       corner;
        logic             fin;
    } t_res;

    // Corner sequencer holding the accepted pair.
    t_item      r_h;
    logic       r_h_vld;
    logic [2:0] r_cnt;
    logic       w_last_sub;
    logic       w_en;

    // Pipeline registers.
    t_beat            r_pipe [NST];
    t_beat            n_pipe [NST];
    logic [NST-1:0]   r_pv;

    // Contact collector: pending contact and output register.
    t_res  r_p;
    logic  r_p_vld;
    t_res  r_o;
    logic  r_o_vld;
    t_res  n_p;
    logic  n_p_vld;
    t_res  n_o;
    logic  n_o_vld;
    logic  w_take;
    t_res  w_lres;

    // Sequencer control: a box pair issues one corner beat per cycle while the pipeline is not stalled.
    assign w_last_sub = (r_h.mode != npcg_pkg::MODE_BOX_PLN) ||
                        (r_cnt == 3'(npcg_pkg::NUM_CORNERS - 1));
    assign o_ready    = !r_h_vld || (w_en && w_last_sub);
    assign w_en       = !r_pv[NST-1] || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
            r_cnt   <= 3'd0;
        end else if (i_valid && o_ready) begin
            r_h_vld <= 1'b1;
            r_cnt   <= 3'd0;
        end else if (r_h_vld && w_en) begin
            if (w_last_sub) begin
                r_h_vld <= 1'b0;
                r_cnt   <= 3'd0;
            end else begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    // Capture the pair payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_h.mode <= i_mode;
            r_h.tag  <= i_pair_tag;
            r_h.a    <= {i_a_z, i_a_y, i_a_x};
            r_h.h    <= {i_a_ext_z, i_a_ext_y, i_a_ext_x};
            r_h.b    <= {i_b_z, i_b_y, i_b_x};
            r_h.bs   <= i_b_scalar;
        end
    end

    // Stage 0: form the center offset, the plane-side center or the box corner.
    always_comb begin
        n_pipe[0]      = '0;
        n_pipe[0].mode = r_h.mode;
        n_pipe[0].tag  = r_h.tag;
        n_pipe[0].a    = r_h.a;
        n_pipe[0].h0   = r_h.h[0];
        n_pipe[0].b    = r_h.b;
        n_pipe[0].bs   = r_h.bs;
        n_pipe[0].eoi  = w_last_sub;
        n_pipe[0].corner = (r_h.mode == npcg_pkg::MODE_BOX_PLN) ? r_cnt : 3'd0;
        for (int i = 0; i < 3; i++) begin
            case (r_h.mode)
                npcg_pkg::MODE_SPH_SPH: begin
                    n_pipe[0].u[i] = UW'($signed({r_h.a[i][31], r_h.a[i]}) -
                                         $signed({r_h.b[i][31], r_h.b[i]}));
                end
                npcg_pkg::MODE_BOX_PLN: begin
                    if (npcg_pkg::CORNER_NEG[i][r_cnt]) begin
                        n_pipe[0].u[i] = UW'($signed({r_h.a[i][31], r_h.a[i]}) -
                                             $signed({2'b00, r_h.h[i]}));
                    end else begin
                        n_pipe[0].u[i] = UW'($signed({r_h.a[i][31], r_h.a[i]}) +
                                             $signed({2'b00, r_h.h[i]}));
                    end
                end
                default: begin
                    n_pipe[0].u[i] = {r_h.a[i][31], r_h.a[i]};
                end
            endcase
        end
    end

    // Stages 1 and up.
    for (genvar k = 1; k < NST; k++) begin : g_stage
        if (k == S_MUL1) begin : g_mul1
            // Square the offset, or multiply coordinate by plane normal.
            always_comb begin
                logic signed [UW-1:0] x;
                logic signed [UW-1:0] y;
                logic signed [PW-1:0] pr;
                n_pipe[k] = r_pipe[k-1];
                for (int i = 0; i < 3; i++) begin
                    x = $signed(r_pipe[k-1].u[i]);
                    if (r_pipe[k-1].mode == npcg_pkg::MODE_SPH_SPH) begin
                        y = x;
                    end else begin
                        y = $signed({r_pipe[k-1].b[i][31], r_pipe[k-1].b[i]});
                    end
                    pr = x * y;
                    n_pipe[k].prod[i] = pr;
                end
            end
        end else if (k == S_TRN) begin : g_trn
            // Drop fraction bits of plane products, rounding toward zero.
            always_comb begin
                logic signed [PW-1:0] p;
                logic signed [PW-1:0] bias;
                n_pipe[k] = r_pipe[k-1];
                bias = $signed({{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}});
                for (int i = 0; i < 3; i++) begin
                    p = $signed(r_pipe[k-1].prod[i]);
                    if (r_pipe[k-1].mode != npcg_pkg::MODE_SPH_SPH) begin
                        if (p[PW-1]) begin
                            p = p + bias;
                        end
                        n_pipe[k].prod[i] = p >>> FRAC_BITS;
                    end
                end
            end
        end else if (k == S_ACC) begin : g_acc
            // Three-term sum.
            always_comb begin
                n_pipe[k] = r_pipe[k-1];
                n_pipe[k].acc = ACCW'($signed(r_pipe[k-1].prod[0])) +
                                ACCW'($signed(r_pipe[k-1].prod[1])) +
                                ACCW'($signed(r_pipe[k-1].prod[2]));
            end
        end else if (k == S_CLS) begin : g_cls
            // Plane gap and hit test; set up the root and division for sphere pairs.
            always_comb begin
                logic signed [ACCW-1:0] accs;
                logic signed [ACCW-1:0] bse;
                logic signed [ACCW-1:0] plane;
                logic signed [ACCW-1:0] gap;
                logic [ACCW-1:0]        pabs;
                logic [UW-1:0]          uabs;
                n_pipe[k] = r_pipe[k-1];
                accs  = $signed(r_pipe[k-1].acc);
                bse   = ACCW'($signed(r_pipe[k-1].bs));
                plane = accs - bse;
                gap   = '0;
                pabs  = '0;
                uabs  = '0;
                n_pipe[k].hit  = 1'b0;
                n_pipe[k].root = '0;
                n_pipe[k].quo  = '0;
                n_pipe[k].srem = r_pipe[k-1].acc[SW-1:0];
                for (int i = 0; i < 3; i++) begin
                    uabs = r_pipe[k-1].u[i][UW-1] ? (UW'(0) - r_pipe[k-1].u[i])
                                                  : r_pipe[k-1].u[i];
                    n_pipe[k].drem[i] = {uabs, {FRAC_BITS{1'b0}}};
                end
                case (r_pipe[k-1].mode)
                    npcg_pkg::MODE_SPH_PLN: begin
                        gap  = plane - $signed({{(ACCW-31){1'b0}}, r_pipe[k-1].h0});
                        pabs = plane[ACCW-1] ? ACCW'(-plane) : ACCW'(plane);
                        n_pipe[k].hit    = gap[ACCW-1];
                        n_pipe[k].depth  = npcg_pkg::sat32(npcg_pkg::SATW'(gap));
                        n_pipe[k].normal = r_pipe[k-1].b;
                        n_pipe[k].pneg   = plane[ACCW-1];
                        n_pipe[k].pmag   = (pabs > ACCW'({MAGW{1'b1}})) ? {MAGW{1'b1}}
                                                                       : pabs[MAGW-1:0];
                    end
                    npcg_pkg::MODE_BOX_PLN: begin
                        gap = plane;
                        n_pipe[k].hit    = gap[ACCW-1];
                        n_pipe[k].depth  = npcg_pkg::sat32(npcg_pkg::SATW'(gap));
                        n_pipe[k].normal = r_pipe[k-1].b;
                        for (int i = 0; i < 3; i++) begin
                            n_pipe[k].point[i] = npcg_pkg::sat32(
                                npcg_pkg::SATW'($signed(r_pipe[k-1].u[i])));
                        end
                    end
                    default: begin
                        n_pipe[k].hit = 1'b0;
                    end
                endcase
            end
        end else if (k >= S_SQ0 && k < S_DST) begin : g_sq
            // One result bit of the integer square root per stage.
            localparam int J = RW - 1 - (k - S_SQ0);
            always_comb begin
                logic [ACCW-1:0] t;
                n_pipe[k] = r_pipe[k-1];
                t = (ACCW'(r_pipe[k-1].root) << (J + 1)) + (ACCW'(1) << (2 * J));
                if (ACCW'(r_pipe[k-1].srem) >= t) begin
                    n_pipe[k].srem    = SW'(ACCW'(r_pipe[k-1].srem) - t);
                    n_pipe[k].root[J] = 1'b1;
                end
            end
        end else if (k == S_DST) begin : g_dst
            // Sphere overlap test against the center distance.
            always_comb begin
                logic signed [35:0] sumd;
                n_pipe[k] = r_pipe[k-1];
                sumd = $signed({5'b0, r_pipe[k-1].h0}) +
                       $signed({{4{r_pipe[k-1].bs[31]}}, r_pipe[k-1].bs}) -
                       $signed({3'b0, r_pipe[k-1].root});
                if (r_pipe[k-1].mode == npcg_pkg::MODE_SPH_SPH) begin
                    n_pipe[k].hit   = (sumd > 36'sd0);
                    n_pipe[k].depth = npcg_pkg::sat32(npcg_pkg::SATW'(sumd));
                end
            end
        end else if (k >= S_DV0 && k < S_NRM) begin : g_dv
            // One normal magnitude bit per stage on each axis.
            localparam int J = FRAC_BITS - (k - S_DV0);
            always_comb begin
                logic [DVW-1:0] den;
                n_pipe[k] = r_pipe[k-1];
                den = DVW'(r_pipe[k-1].root) << J;
                for (int i = 0; i < 3; i++) begin
                    if (r_pipe[k-1].drem[i] >= den) begin
                        n_pipe[k].drem[i]   = r_pipe[k-1].drem[i] - den;
                        n_pipe[k].quo[i][J] = 1'b1;
                    end
                end
            end
        end else if (k == S_NRM) begin : g_nrm
            // Signed normal for sphere pairs; operands of the point correction.
            always_comb begin
                logic [QW-1:0] nmag;
                logic          nneg;
                logic [31:0]   nz;
                n_pipe[k] = r_pipe[k-1];
                nmag = '0;
                nneg = 1'b0;
                nz   = '0;
                for (int i = 0; i < 3; i++) begin
                    case (r_pipe[k-1].mode)
                        npcg_pkg::MODE_SPH_SPH: begin
                            if (r_pipe[k-1].root == '0) begin
                                // Coincident centers: normal points along +x.
                                nmag = (i == 0) ? (QW'(1) << FRAC_BITS) : '0;
                                nneg = 1'b0;
                            end else begin
                                nmag = r_pipe[k-1].quo[i];
                                nneg = r_pipe[k-1].u[i][UW-1];
                            end
                            nz = {{(32-QW){1'b0}}, nmag};
                            n_pipe[k].normal[i] = nneg ? (32'd0 - nz) : nz;
                            n_pipe[k].mx[i]     = {1'b0, r_pipe[k-1].h0};
                            n_pipe[k].ylo[i]    = SPLIT'(nmag);
                            n_pipe[k].yhi[i]    = '0;
                            n_pipe[k].qneg[i]   = nneg;
                        end
                        npcg_pkg::MODE_SPH_PLN: begin
                            n_pipe[k].mx[i]   = r_pipe[k-1].b[i][31] ?
                                                (32'd0 - r_pipe[k-1].b[i]) : r_pipe[k-1].b[i];
                            n_pipe[k].ylo[i]  = r_pipe[k-1].pmag[SPLIT-1:0];
                            n_pipe[k].yhi[i]  = r_pipe[k-1].pmag[MAGW-1:SPLIT];
                            n_pipe[k].qneg[i] = r_pipe[k-1].b[i][31] ^ r_pipe[k-1].pneg;
                        end
                        default: begin
                            n_pipe[k].mx[i] = '0;
                        end
                    endcase
                end
            end
        end else if (k == S_MUL2) begin : g_mul2
            // Partial products of the point correction.
            always_comb begin
                n_pipe[k] = r_pipe[k-1];
                for (int i = 0; i < 3; i++) begin
                    n_pipe[k].pplo[i] = PPW'(r_pipe[k-1].mx[i]) * PPW'(r_pipe[k-1].ylo[i]);
                    n_pipe[k].pphi[i] = PPW'(r_pipe[k-1].mx[i]) * PPW'(r_pipe[k-1].yhi[i]);
                end
            end
        end else if (k == S_QS) begin : g_qs
            // Recombine, drop fraction bits and clamp where the point saturates anyway.
            always_comb begin
                logic [FW-1:0] full;
                logic [FW-1:0] shf;
                n_pipe[k] = r_pipe[k-1];
                for (int i = 0; i < 3; i++) begin
                    full = (FW'(r_pipe[k-1].pphi[i]) << SPLIT) + FW'(r_pipe[k-1].pplo[i]);
                    shf  = full >> FRAC_BITS;
                    if (shf >= (FW'(1) << (QMW - 1))) begin
                        n_pipe[k].qm[i] = QMW'(1) << (QMW - 1);
                    end else begin
                        n_pipe[k].qm[i] = shf[QMW-1:0];
                    end
                end
            end
        end else begin : g_pnt
            // Contact point for sphere cases: center minus the signed correction.
            always_comb begin
                logic signed [QMW+1:0] ae;
                logic signed [QMW+1:0] qe;
                logic signed [QMW+1:0] p;
                n_pipe[k] = r_pipe[k-1];
                for (int i = 0; i < 3; i++) begin
                    ae = (QMW+2)'($signed(r_pipe[k-1].a[i]));
                    qe = $signed({2'b00, r_pipe[k-1].qm[i]});
                    p  = r_pipe[k-1].qneg[i] ? (ae + qe) : (ae - qe);
                    if (r_pipe[k-1].mode == npcg_pkg::MODE_SPH_SPH ||
                        r_pipe[k-1].mode == npcg_pkg::MODE_SPH_PLN) begin
                        n_pipe[k].point[i] = npcg_pkg::sat32(npcg_pkg::SATW'(p));
                    end
                end
            end
        end
    end

    // Pipeline advance: valid bits reset, payload does not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (w_en) begin
            r_pv <= {r_pv[NST-2:0], r_h_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < NST; s++) begin
                r_pipe[s] <= n_pipe[s];
            end
        end
    end

    // Collector: a contact waits in the pending register until it is known whether
    // another contact of the same pair follows, which settles its last flag.
    always_comb begin
        w_lres.tag    = r_pipe[NST-1].tag;
        w_lres.point  = r_pipe[NST-1].point;
        w_lres.normal = r_pipe[NST-1].normal;
        w_lres.depth  = r_pipe[NST-1].depth;
        w_lres.corner = r_pipe[NST-1].corner;
        w_lres.fin    = r_pipe[NST-1].eoi;

        n_o     = r_o;
        n_o_vld = r_o_vld && !i_ready;
        n_p     = r_p;
        n_p_vld = r_p_vld;
        w_take  = 1'b1;

        if (r_pv[NST-1] && r_pipe[NST-1].hit) begin
            w_take = !r_p_vld || !r_o_vld || i_ready;
            if (!r_p_vld) begin
                n_p     = w_lres;
                n_p_vld = 1'b1;
            end else if (!r_o_vld || i_ready) begin
                n_o     = r_p;
                n_o_vld = 1'b1;
                n_p     = w_lres;
            end
        end else begin
            if (r_p_vld && r_p.fin && (!r_o_vld || i_ready)) begin
                n_o     = r_p;
                n_o_vld = 1'b1;
                n_p_vld = 1'b0;
            end
            if (r_pv[NST-1] && r_pipe[NST-1].eoi && r_p_vld && !r_p.fin) begin
                n_p.fin = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_p_vld <= 1'b0;
        end else begin
            r_o_vld <= n_o_vld;
            r_p_vld <= n_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o <= n_o;
        r_p <= n_p;
    end

    // Result ports.
    assign o_valid    = r_o_vld;
    assign o_tag_out  = r_o.tag;
    assign o_point_x  = r_o.point[0];
    assign o_point_y  = r_o.point[1];
    assign o_point_z  = r_o.point[2];
    assign o_normal_x = r_o.normal[0];
    assign o_normal_y = r_o.normal[1];
    assign o_normal_z = r_o.normal[2];
    assign o_depth    = r_o.depth;
    assign o_corner   = r_o.corner;
    assign o_last     = r_o.fin;

`ifndef NO_ASSERTIONS
    // The corner count only runs while a box pair is held.
    a_cnt_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 3'd0) |-> (r_h_vld && r_h.mode == npcg_pkg::MODE_BOX_PLN))
        else $error("corner count runs without a box pair");

    // A non-final contact on the output means its successor is pending.
    a_nonlast_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !r_o.fin) |-> r_p_vld)
        else $error("non-final contact without a pending successor");

    // A stall freezes the pipeline valid bits.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_pv))
        else $error("pipeline moved during a stall");

    // The end-of-pair mark of a box beat sits on its last corner.
    a_box_eoi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv[0] && r_pipe[0].mode == npcg_pkg::MODE_BOX_PLN) |->
        (r_pipe[0].eoi == (r_pipe[0].corner == 3'(npcg_pkg::NUM_CORNERS - 1))))
        else $error("box end mark on the wrong corner");
`endif

endmodule
